### hdl/mlb_pkg.sv
`default_nettype none
// ============================================================================
// mlb_pkg: shared types and constants of the multi-LED blink controller
// Holds the field widths, the command and mode codes, the per-LED state
// record and the records passed between the front end and the back end.
// ============================================================================
package mlb_pkg;

    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 4;
    localparam int PERIOD_W  = 16;
    localparam int DIM_W     = 8;
    localparam int LEVELS_W  = 16;
    localparam int CFG_W     = 5;
    localparam int ELAPSED_W = 17;
    localparam int DARK_W    = 9;

    // Two-entry command queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_W-1:0]     LED_COUNT_RESET = 5'd16;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_ON    = 2'd1,
        KIND_OFF   = 2'd2,
        KIND_BLINK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ON    = 2'd1,
        MODE_OFF   = 2'd2,
        MODE_BLINK = 2'd3
    } t_mode;

    // State of one LED except its pin level.
    typedef struct packed {
        t_mode                 req;
        t_mode                 prev;
        t_mode                 fol;
        logic [ELAPSED_W-1:0]  elapsed;
        logic [PERIOD_W-1:0]   period;
        logic [DIM_W-1:0]      dim;
        logic [DARK_W-1:0]     dark;
        logic                  phase;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // A classified command as it waits in the queue.
    typedef struct packed {
        t_kind                 kind;
        logic [INDEX_W-1:0]    idx;
        logic [PERIOD_W-1:0]   period;
        logic [DIM_W-1:0]      dim;
        logic                  flagged;
    } t_cmd;

    typedef struct packed {
        logic                  valid;
        t_cmd                  item;
    } t_queue_head;

    typedef struct packed {
        logic                  we;
        logic                  level;
    } t_pin_upd;

endpackage
`default_nettype wire

### hdl/mlb_ram.sv
`default_nettype none
// ============================================================================
// mlb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module mlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/mlb_front.sv
`default_nettype none
// ============================================================================
// mlb_front: command intake and classification
// Accepts transactions, flags commands aimed past the LEDs in use and holds
// them in a two-entry queue for the back end.
// ============================================================================
module mlb_front #(
    parameter int NUM_LEDS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [mlb_pkg::KIND_W-1:0]          i_kind,
    input  wire logic [mlb_pkg::INDEX_W-1:0]         i_led_index,
    input  wire logic [mlb_pkg::PERIOD_W-1:0]        i_blink_period,
    input  wire logic [mlb_pkg::DIM_W-1:0]           i_dim_ratio,
    input  wire logic [$clog2(NUM_LEDS+1)-1:0]       i_active,
    output mlb_pkg::t_queue_head                     o_head,
    input  wire logic                                i_pop
);
    import mlb_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    t_cmd              item;

    assign o_busy = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;

    always_comb begin
        item.kind    = t_kind'(i_kind);
        item.idx     = i_led_index;
        item.period  = i_blink_period;
        item.dim     = i_dim_ratio;
        item.flagged = (t_kind'(i_kind) != KIND_TICK) &&
                       (8'(i_led_index) >= 8'(i_active));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_slot[r_rd_ptr];

endmodule
`default_nettype wire

### hdl/mlb_update.sv
`default_nettype none
// ============================================================================
// mlb_update: next state of one LED
// Applies a tick step or a command to one LED state record and reports
// whether the pin changes.
// ============================================================================
module mlb_update (
    input  mlb_pkg::t_entry    i_entry,
    input  wire logic          i_tick,
    input  wire logic          i_in_use,
    input  mlb_pkg::t_cmd      i_item,
    output mlb_pkg::t_entry    o_entry,
    output mlb_pkg::t_pin_upd  o_pin
);
    import mlb_pkg::*;

    always_comb begin : p_update
        t_entry              e;
        t_mode               fol;
        t_pin_upd            pin;
        logic [DARK_W-1:0]   dc;

        e   = i_entry;
        fol = i_entry.fol;
        pin = '0;
        dc  = '0;

        if (i_tick) begin
            if (e.elapsed != ELAPSED_MAX) begin
                e.elapsed = e.elapsed + 1'b1;
            end
            if (i_in_use) begin
                case (i_entry.req)
                    MODE_ON: begin
                        if (i_entry.prev != MODE_ON) begin
                            pin = '{we: 1'b1, level: 1'b1};
                            fol = MODE_ON;
                        end
                    end
                    MODE_OFF: begin
                        if (i_entry.prev != MODE_OFF) begin
                            pin = '{we: 1'b1, level: 1'b0};
                            fol = MODE_OFF;
                        end
                    end
                    MODE_BLINK: begin
                        if (i_entry.prev != MODE_BLINK) begin
                            e.elapsed = '0;
                            fol       = MODE_BLINK;
                        end
                        if (e.elapsed > ELAPSED_W'(e.period)) begin
                            e.elapsed = '0;
                            if (e.phase) begin
                                if (e.dim != '0) begin
                                    dc = e.dark + 1'b1;
                                    if (dc > DARK_W'(e.dim)) begin
                                        e.dark  = '0;
                                        e.phase = 1'b0;
                                        pin     = '{we: 1'b1, level: 1'b1};
                                    end else begin
                                        e.dark = dc;
                                    end
                                end else begin
                                    e.phase = 1'b0;
                                    pin     = '{we: 1'b1, level: 1'b1};
                                end
                            end else begin
                                e.phase = 1'b1;
                                pin     = '{we: 1'b1, level: 1'b0};
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                e.prev = i_entry.req;
                e.req  = fol;
                e.fol  = fol;
            end
        end else begin
            case (i_item.kind)
                KIND_ON:  e.req = MODE_ON;
                KIND_OFF: e.req = MODE_OFF;
                KIND_BLINK: begin
                    if (i_entry.prev != MODE_BLINK) begin
                        e.elapsed = '0;
                        e.req     = MODE_BLINK;
                    end
                    e.period = i_item.period;
                    e.dim    = i_item.dim;
                end
                default: begin
                end
            endcase
        end

        o_entry = e;
        o_pin   = pin;
    end

endmodule
`default_nettype wire

### hdl/mlb_back.sv
`default_nettype none
// ============================================================================
// mlb_back: command execution and tick sweep
// Pops classified commands, updates the per-LED state memory one entry per
// cycle and strobes one result per command.
// ============================================================================
module mlb_back #(
    parameter int NUM_LEDS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  mlb_pkg::t_queue_head                   i_head,
    output logic                                   o_pop,
    input  wire logic [$clog2(NUM_LEDS+1)-1:0]     i_active,
    output logic                                   o_done,
    output logic                                   o_status,
    output logic [mlb_pkg::LEVELS_W-1:0]           o_led_levels
);
    import mlb_pkg::*;

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_LEDS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_CMD   = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_item, n_item;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_exec_addr, n_exec_addr;
    logic                  r_done, n_done;
    logic                  r_status, n_status;
    logic                  r_rd_valid;
    logic [NUM_LEDS-1:0]   r_valid;
    logic [NUM_LEDS-1:0]   r_pin;

    logic                  rd_en;
    logic                  wr_en;
    logic [ENTRY_W-1:0]    ram_rdata;
    t_entry                rd_entry;
    t_entry                wr_entry;
    t_pin_upd              pin_upd;
    logic                  in_use;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_addr      = r_addr;
        n_exec_addr = r_exec_addr;
        n_done      = 1'b0;
        n_status    = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_item = i_head.item;
                    if (i_head.item.flagged) begin
                        n_done   = 1'b1;
                        n_status = 1'b1;
                    end else begin
                        n_addr  = (i_head.item.kind == KIND_TICK) ? '0 : AW'(i_head.item.idx);
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                rd_en       = 1'b1;
                n_exec_addr = r_addr;
                n_addr      = r_addr + 1'b1;
                n_state     = (r_item.kind == KIND_TICK) ? ST_SWEEP : ST_CMD;
            end
            ST_CMD: begin
                wr_en   = 1'b1;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                wr_en = 1'b1;
                if (r_exec_addr == LAST) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    rd_en       = 1'b1;
                    n_exec_addr = r_addr;
                    n_addr      = r_addr + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_status <= 1'b0;
            r_valid  <= '0;
            r_pin    <= '0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_status <= n_status;
            if (wr_en) begin
                r_valid[r_exec_addr] <= 1'b1;
                if (pin_upd.we) begin
                    r_pin[r_exec_addr] <= pin_upd.level;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_addr      <= n_addr;
        r_exec_addr <= n_exec_addr;
        if (rd_en) begin
            r_rd_valid <= r_valid[r_addr];
        end
    end

    // Entries never written read as the reset state.
    assign rd_entry = r_rd_valid ? t_entry'(ram_rdata) : '0;
    assign in_use   = 8'(r_exec_addr) < 8'(i_active);

    mlb_update u_update (
        .i_entry  (rd_entry),
        .i_tick   (r_item.kind == KIND_TICK),
        .i_in_use (in_use),
        .i_item   (r_item),
        .o_entry  (wr_entry),
        .o_pin    (pin_upd)
    );

    mlb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_LEDS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_exec_addr),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    generate
        if (NUM_LEDS >= LEVELS_W) begin : g_levels_cut
            assign o_led_levels = r_pin[LEVELS_W-1:0];
        end else begin : g_levels_pad
            assign o_led_levels = LEVELS_W'(r_pin);
        end
    endgenerate

    assign o_done   = r_done;
    assign o_status = r_status;

endmodule
`default_nettype wire

### hdl/multi_led_blink_controller.sv
`default_nettype none
// ============================================================================
// multi_led_blink_controller: on/off/blink control for a bank of LEDs
// Takes tick and per-LED command transactions and reports the LED pin levels
// after each one.
// ============================================================================
// A transaction is taken at a rising edge where start is high and busy is
// low. Every transaction yields exactly one result: o_done is high for one
// cycle with o_led_levels and o_status, and the receiver cannot stall it, so
// results must be captured in that cycle. Transactions first enter a
// two-entry queue, and busy is high only while that queue is full. In the
// back end a tick sweeps the per-LED state memory one entry per cycle: every
// entry ages and the entries below the active count are stepped. An on, off
// or blink command for an LED in use does one memory read and one write; a
// command for an LED at or above the active count reports status 1 without
// touching any state. The result strobe follows in the cycle after the last
// write. The state memory needs no clearing pass after reset: one valid bit
// per entry makes an unwritten entry read as its reset state. The led_count
// register is written over its own valid/ready channel (always ready); the
// user must write it only while no transaction is outstanding, which the
// block does not enforce. Values above NUM_LEDS act as NUM_LEDS.
// ============================================================================
module multi_led_blink_controller #(
    parameter int NUM_LEDS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mlb_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [mlb_pkg::INDEX_W-1:0]   i_led_index,
    input  wire logic [mlb_pkg::PERIOD_W-1:0]  i_blink_period,
    input  wire logic [mlb_pkg::DIM_W-1:0]     i_dim_ratio,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mlb_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_done,
    output logic [mlb_pkg::LEVELS_W-1:0]       o_led_levels,
    output logic                               o_status
);
    import mlb_pkg::*;

    localparam int CW = $clog2(NUM_LEDS + 1);

    logic [CFG_W-1:0] r_led_count;
    logic [CW-1:0]    active;
    t_queue_head      head;
    logic             pop;

    // The configuration channel never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= LED_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_led_count <= i_cfg_data;
        end
    end

    // Number of LEDs actually stepped and addressable.
    assign active = (int'(r_led_count) > NUM_LEDS) ? CW'(NUM_LEDS) : CW'(r_led_count);

    mlb_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_kind         (i_kind),
        .i_led_index    (i_led_index),
        .i_blink_period (i_blink_period),
        .i_dim_ratio    (i_dim_ratio),
        .i_active       (active),
        .o_head         (head),
        .i_pop          (pop)
    );

    mlb_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_active     (active),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_led_levels (o_led_levels)
    );

endmodule
`default_nettype wire

### hdl/mlb_checker.sv
`default_nettype none
// ============================================================================
// mlb_checker: port-level checks of the multi-LED blink controller
// Watches the top-level ports and flags result and handshake behavior that
// the design must never show.
// ============================================================================
module mlb_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          o_done,
    input  wire logic [mlb_pkg::LEVELS_W-1:0]  o_led_levels,
    input  wire logic                          o_status
);
    import mlb_pkg::*;

    // No result may appear in the first cycle out of reset.
    a_no_done_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_done)
        else $error("result strobe right after reset");

    // All LEDs are dark in the first cycle out of reset.
    a_dark_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (o_led_levels == '0))
        else $error("LED levels not cleared by reset");

    // The error flag only qualifies a result strobe.
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status |-> o_done)
        else $error("status raised without a result");

    // The queue can only fill up through a transaction taken the cycle before.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a new transaction");

endmodule

bind multi_led_blink_controller mlb_checker u_mlb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_led_levels (o_led_levels),
    .o_status     (o_status)
);
`default_nettype wire

### verif/tb_multi_led_blink_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_led_blink_controller: self-checking bench for the LED controller
// Sends tick and on/off/blink transactions in random bursts and predicts the
// pin levels and status of each one with an untimed model of the LED bank.
// Every result strobe is checked against the oldest prediction.
// ============================================================================
module tb_multi_led_blink_controller;
    import mlb_pkg::*;

    localparam int NUM_LEDS     = 16;
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 40;    // settle time after the last result
    localparam int MAX_REPORTS  = 40;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // One input transaction and the result it produces.
    typedef struct packed {
        t_kind                kind;
        logic [INDEX_W-1:0]   idx;
        logic [PERIOD_W-1:0]  period;
        logic [DIM_W-1:0]     dim;
    } t_led_cmd;

    typedef struct packed {
        logic [LEVELS_W-1:0]  levels;
        logic                 status;
    } t_led_result;

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block under test.
    // ------------------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic [KIND_W-1:0]    i_kind         = '0;
    logic [INDEX_W-1:0]   i_led_index    = '0;
    logic [PERIOD_W-1:0]  i_blink_period = '0;
    logic [DIM_W-1:0]     i_dim_ratio    = '0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 busy;
    logic                 o_cfg_ready;
    logic                 o_done;
    logic [LEVELS_W-1:0]  o_led_levels;
    logic                 o_status;

    always #5 i_clk = ~i_clk;

    multi_led_blink_controller #(
        .NUM_LEDS(NUM_LEDS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_led_index    (i_led_index),
        .i_blink_period (i_blink_period),
        .i_dim_ratio    (i_dim_ratio),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_led_levels   (o_led_levels),
        .o_status       (o_status)
    );

    // ------------------------------------------------------------------------
    // Model of the LED bank. It is updated once per accepted transaction, in
    // acceptance order, so it never needs to know about the block's timing.
    // ------------------------------------------------------------------------
    t_mode                wanted_mode [NUM_LEDS];
    t_mode                last_mode   [NUM_LEDS];
    t_mode                next_mode   [NUM_LEDS];
    logic [ELAPSED_W-1:0] age         [NUM_LEDS];
    logic [PERIOD_W-1:0]  half_period [NUM_LEDS];
    logic [DIM_W-1:0]     dim_len     [NUM_LEDS];
    logic [DARK_W-1:0]    dark_cnt    [NUM_LEDS];
    logic                 in_dark     [NUM_LEDS];
    logic                 lit         [NUM_LEDS];
    logic [CFG_W-1:0]     led_count_m;

    t_led_result pending_levels [$];
    int          error_count  = 0;
    int          burst_left   = 0;
    int          stall_cycles = 0;

    function automatic void clear_led_bank();
        for (int n = 0; n < NUM_LEDS; n++) begin
            wanted_mode[n] = MODE_IDLE;
            last_mode[n]   = MODE_IDLE;
            next_mode[n]   = MODE_IDLE;
            age[n]         = '0;
            half_period[n] = '0;
            dim_len[n]     = '0;
            dark_cnt[n]    = '0;
            in_dark[n]     = 1'b0;
            lit[n]         = 1'b0;
        end
        led_count_m = LED_COUNT_RESET;
    endfunction

    // The elapsed time of a blinking LED has passed its half-period. A lit
    // LED goes dark; a dark LED stays dark for dim+1 periods, then lights.
    function automatic void end_blink_period(input int n);
        age[n] = '0;
        if (in_dark[n]) begin
            if (dim_len[n] != '0) begin
                dark_cnt[n] = dark_cnt[n] + 1'b1;
                if (dark_cnt[n] > dim_len[n]) begin
                    dark_cnt[n] = '0;
                    lit[n]      = 1'b1;
                    in_dark[n]  = 1'b0;
                end
            end else begin
                lit[n]     = 1'b1;
                in_dark[n] = 1'b0;
            end
        end else begin
            lit[n]     = 1'b0;
            in_dark[n] = 1'b1;
        end
    endfunction

    // One tick's worth of work for an LED in use. The requested mode takes
    // effect only when it differs from the mode seen on the previous tick.
    function automatic void step_led_mode(input int n);
        case (wanted_mode[n])
            MODE_ON: begin
                if (last_mode[n] != MODE_ON) begin
                    lit[n]       = 1'b1;
                    next_mode[n] = MODE_ON;
                end
            end
            MODE_OFF: begin
                if (last_mode[n] != MODE_OFF) begin
                    lit[n]       = 1'b0;
                    next_mode[n] = MODE_OFF;
                end
            end
            MODE_BLINK: begin
                if (last_mode[n] != MODE_BLINK) begin
                    age[n]       = '0;
                    next_mode[n] = MODE_BLINK;
                end
                if (age[n] > half_period[n])
                    end_blink_period(n);
            end
            default: ;
        endcase
        last_mode[n]   = wanted_mode[n];
        wanted_mode[n] = next_mode[n];
    endfunction

    function automatic t_led_result predict_levels(input t_led_cmd c);
        int          active;
        t_led_result r;
        active   = (led_count_m > NUM_LEDS) ? NUM_LEDS : int'(led_count_m);
        r.status = STATUS_OK;
        if (c.kind == KIND_TICK) begin
            // Time runs for every LED, in use or not, and saturates.
            for (int n = 0; n < NUM_LEDS; n++)
                if (age[n] != ELAPSED_MAX)
                    age[n] = age[n] + 1'b1;
            for (int n = 0; n < active; n++)
                step_led_mode(n);
        end else if (c.idx >= active) begin
            r.status = STATUS_BAD_INDEX;
        end else if (c.kind == KIND_ON) begin
            wanted_mode[c.idx] = MODE_ON;
        end else if (c.kind == KIND_OFF) begin
            wanted_mode[c.idx] = MODE_OFF;
        end else begin
            // A repeated blink only updates the timing of a running blink.
            if (last_mode[c.idx] != MODE_BLINK) begin
                age[c.idx]         = '0;
                wanted_mode[c.idx] = MODE_BLINK;
            end
            half_period[c.idx] = c.period;
            dim_len[c.idx]     = c.dim;
        end
        for (int n = 0; n < LEVELS_W; n++)
            r.levels[n] = lit[n];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting and the result checker. The block cannot hold a
    // result off, so every strobe is compared in the cycle it appears.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_led_result want;
        if (i_rst_n && o_done) begin
            if (pending_levels.size() == 0) begin
                report_mismatch("result strobe with no transaction outstanding");
            end else begin
                want = pending_levels.pop_front();
                if (o_led_levels !== want.levels)
                    report_mismatch($sformatf("led_levels %h, expected %h",
                                              o_led_levels, want.levels));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              o_status, want.status));
            end
        end
    end

    // The watchdog ends a run in which no handshake of any kind happens for
    // far longer than the slowest legal transaction plus the longest gap.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[multi_led_blink_controller] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Transaction drivers.
    // ------------------------------------------------------------------------

    // Presents one command and holds it until accepted. Start stays high
    // inside a burst, so back-to-back transactions see no idle cycle; when a
    // burst ends, a random gap of zero or more cycles follows.
    task automatic send_cmd(input t_led_cmd c);
        int gap;
        start          <= 1'b1;
        i_kind         <= c.kind;
        i_led_index    <= c.idx;
        i_blink_period <= c.period;
        i_dim_ratio    <= c.dim;
        do @(posedge i_clk); while (busy);
        pending_levels.push_back(predict_levels(c));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic issue(input t_kind k, input int idx, input int period, input int dim);
        t_led_cmd c;
        c.kind   = k;
        c.idx    = idx[INDEX_W-1:0];
        c.period = period[PERIOD_W-1:0];
        c.dim    = dim[DIM_W-1:0];
        send_cmd(c);
    endtask

    // Lowers start and waits until every outstanding transaction has
    // produced its result. Each transaction yields exactly one result, so an
    // empty queue means the block is idle.
    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_led_count(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        led_count_m = value;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random field generators. Short periods and dim ratios keep blinks
    // toggling often; now and then the full field range is used.
    // ------------------------------------------------------------------------
    function automatic t_led_cmd random_fields();
        t_led_cmd c;
        c.kind   = t_kind'($urandom_range(0, 3));
        c.idx    = INDEX_W'($urandom_range(0, 15));
        c.period = PERIOD_W'($urandom_range(0, 16'hFFFF));
        c.dim    = DIM_W'($urandom_range(0, 8'hFF));
        return c;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return PERIOD_W'($urandom_range(0, 6));
        else if (roll < 96)
            return PERIOD_W'($urandom_range(0, 40));
        return PERIOD_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return DIM_W'($urandom_range(0, 3));
        else if (roll < 92)
            return DIM_W'($urandom_range(0, 10));
        return DIM_W'($urandom_range(0, 8'hFF));
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Every command kind and the field extremes at the reset LED count.
    task automatic test_directed_modes();
        issue(KIND_TICK, 15, 16'hFFFF, 8'hFF);  // tick ignores its other fields
        issue(KIND_ON, 0, 0, 0);
        issue(KIND_ON, 15, 16'hFFFF, 8'hFF);
        issue(KIND_TICK, 0, 0, 0);
        issue(KIND_OFF, 0, 0, 0);
        issue(KIND_TICK, 0, 0, 0);
        issue(KIND_BLINK, 1, 0, 0);             // plain blink, shortest period
        repeat (3) issue(KIND_TICK, 0, 0, 0);
        issue(KIND_BLINK, 2, 1, 2);             // dimmed blink
        issue(KIND_BLINK, 1, 16'hFFFF, 8'hFF);  // running blink keeps its time
        repeat (6) issue(KIND_TICK, 0, 0, 0);
    endtask

    // LED count extremes: zero flags every command and steps nothing, values
    // above the bank size act as the bank size, and an LED taken out of use
    // keeps aging so that it expires at once when it comes back.
    task automatic test_led_count_extremes();
        write_led_count(5'd0);
        issue(KIND_ON, 0, 0, 0);
        issue(KIND_TICK, 0, 0, 0);
        write_led_count(5'd31);
        issue(KIND_OFF, 15, 0, 0);
        issue(KIND_TICK, 0, 0, 0);
        write_led_count(5'd2);
        repeat (3) issue(KIND_TICK, 0, 0, 0);
        issue(KIND_ON, 2, 0, 0);
        write_led_count(LED_COUNT_RESET);
        issue(KIND_TICK, 0, 0, 0);
    endtask

    // Mostly well-formed traffic: a command for an LED in use followed by a
    // run of ticks, so blinks reach their dark and lit phases. The rest is
    // noise with every field fully random. Every transaction sent counts.
    task automatic test_random_traffic(input logic [CFG_W-1:0] count_setting,
                                       input int n_items);
        int       sent;
        int       active;
        int       run;
        int       roll;
        t_led_cmd c;
        write_led_count(count_setting);
        active = (count_setting > NUM_LEDS) ? NUM_LEDS : int'(count_setting);
        sent   = 0;
        while (sent < n_items) begin
            if (active > 0 && $urandom_range(0, 4) != 0) begin
                c      = random_fields();
                roll   = $urandom_range(0, 9);
                c.kind = (roll < 3) ? KIND_ON : (roll < 5) ? KIND_OFF : KIND_BLINK;
                c.idx  = INDEX_W'($urandom_range(0, active - 1));
                c.period = pick_period();
                c.dim    = pick_dim();
                send_cmd(c);
                sent++;
                run = $urandom_range(1, 10);
                repeat (run) begin
                    c      = random_fields();
                    c.kind = KIND_TICK;
                    send_cmd(c);
                    sent++;
                end
            end else begin
                c = random_fields();
                send_cmd(c);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        clear_led_bank();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_modes();
        test_led_count_extremes();
        test_random_traffic(LED_COUNT_RESET, 300);
        test_random_traffic(5'd31, 250);
        test_random_traffic(5'd1, 200);
        test_random_traffic(5'd0, 100);
        test_random_traffic(CFG_W'($urandom_range(2, 15)), 350);
        test_random_traffic(CFG_W'($urandom_range(0, 31)), 300);
        test_random_traffic(LED_COUNT_RESET, 300);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_levels.size() == 0)
            $display("[multi_led_blink_controller] OK");
        else
            $display("[multi_led_blink_controller] ERROR");
        $finish;
    end

endmodule

### multi_led_blink_controller.f
hdl/mlb_pkg.sv
hdl/mlb_ram.sv
hdl/mlb_front.sv
hdl/mlb_update.sv
hdl/mlb_back.sv
hdl/multi_led_blink_controller.sv
hdl/mlb_checker.sv
verif/tb_multi_led_blink_controller.sv
